// ===== src/cmt_pkg.sv =====
// Shared types and constants for the connection map table.
// No dependencies; imported by connection_map_table and cmt_checker.
package cmt_pkg;

  // Field widths fixed by the item format
  localparam int MODE_W = 3;
  localparam int PORT_W = 16;
  localparam int ADDR_W = 32;
  localparam int SLOT_W = 4;
  localparam int FIN_W  = 2;
  localparam int STAT_W = 2;

  // FIN count given to every new entry
  localparam logic [FIN_W-1:0] FIN_START = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_MISS = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_FULL = 2'd2;

  // Operation codes
  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 3'd0,
    MODE_CLIENT = 3'd1,
    MODE_MAPPED = 3'd2,
    MODE_DELETE = 3'd3,
    MODE_CLEAR  = 3'd4
  } mode_e;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_DEL_CAP,
    S_WALK,
    S_FINISH
  } state_e;

  // Stored part of one entry; FIN count and active flag follow from it
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [PORT_W-1:0] sport;
    logic [PORT_W-1:0] mport;
    logic              data;
  } entry_t;

endpackage

// ===== src/connection_map_table.sv =====
// Connection map table: entry and recency-rank memories with a walking sequencer.
// Depends on cmt_pkg.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+-------------------------------------
//   in      | in        | in_valid_i / in_stall_o    | mode, keys, data_flag, target_slot
//   out     | out       | out_valid_o / out_stall_i  | hit, slot, entry fields, status
//
// Lookup and insert walk the whole table; delete first reads its target slot, then walks;
// the walk reads one entry of the entry and rank memories per cycle.
// Clear all, a refused insert, a missed delete and an unknown mode skip the walk.
// One item is in work at a time; the next item is taken as soon as the result sits in the
// output register, even while out_stall_i holds it there.
// Reset clears valid bits and control state; the memories themselves need no clearing.
module connection_map_table #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [cmt_pkg::MODE_W-1:0]   mode_i,
  input  logic [cmt_pkg::PORT_W-1:0]   key_source_port_i,
  input  logic [cmt_pkg::PORT_W-1:0]   key_mapped_port_i,
  input  logic [cmt_pkg::ADDR_W-1:0]   key_address_i,
  input  logic                         data_flag_i,
  input  logic [cmt_pkg::SLOT_W-1:0]   target_slot_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         hit_o,
  output logic [cmt_pkg::SLOT_W-1:0]   slot_o,
  output logic [cmt_pkg::PORT_W-1:0]   out_source_port_o,
  output logic [cmt_pkg::PORT_W-1:0]   out_mapped_port_o,
  output logic [cmt_pkg::ADDR_W-1:0]   out_address_o,
  output logic [cmt_pkg::FIN_W-1:0]    fin_left_o,
  output logic                         out_data_flag_o,
  output logic                         active_flag_o,
  output logic [cmt_pkg::STAT_W-1:0]   status_o
);
  import cmt_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

  // Sequencer and item registers
  state_e              state_q, state_d;
  logic [MODE_W-1:0]   mode_q;
  logic [PORT_W-1:0]   sport_q, mport_q;
  logic [ADDR_W-1:0]   addr_q;
  logic                df_q;
  logic [SLOT_W-1:0]   ts_q;

  // Table occupancy
  logic [TABLE_DEPTH-1:0] valid_q;
  logic [CNT_W-1:0]       count_q;

  // Walk pointers
  logic [CNT_W-1:0]    issue_q;
  logic                pend_q;
  logic [IDX_W-1:0]    pend_idx_q;

  // Memories and their registered read data
  entry_t              entry_mem [TABLE_DEPTH];
  logic [IDX_W-1:0]    rank_mem  [TABLE_DEPTH];
  entry_t              rd_entry_q;
  logic [IDX_W-1:0]    rd_rank_q;

  // Walk results
  logic                best_found_q;
  logic [IDX_W-1:0]    best_idx_q;
  logic [IDX_W-1:0]    best_rank_q;
  entry_t              best_entry_q;
  logic                free_found_q;
  logic [IDX_W-1:0]    free_idx_q;
  logic [IDX_W-1:0]    del_rank_q;
  logic                fail_q;

  // Output register
  logic                out_valid_q;
  logic                hit_q;
  logic [SLOT_W-1:0]   slot_q;
  logic [PORT_W-1:0]   osport_q, omport_q;
  logic [ADDR_W-1:0]   oaddr_q;
  logic [FIN_W-1:0]    fin_q;
  logic                odata_q, active_q;
  logic [STAT_W-1:0]   status_q;

  // Combinational control
  logic                accept, issuing, walk_done, out_free, load_out;
  logic                full, ts_in_range, ts_ok;
  logic [IDX_W-1:0]    tidx;
  logic                rd_en;
  logic [IDX_W-1:0]    rd_addr;
  logic                rank_we;
  logic [IDX_W-1:0]    rank_wa;
  logic [IDX_W-1:0]    rank_wd;
  logic                entry_we;
  entry_t              entry_wd;
  logic                pend_valid, pend_match, pend_better, pend_free;

  // Result being formed
  logic                res_hit;
  logic [SLOT_W-1:0]   res_slot;
  logic [PORT_W-1:0]   res_sport, res_mport;
  logic [ADDR_W-1:0]   res_addr;
  logic [FIN_W-1:0]    res_fin;
  logic                res_data, res_active;
  logic [STAT_W-1:0]   res_status;

  // Handshake and walk status
  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign full        = (count_q == DEPTH_C);
  assign issuing     = (state_q == S_WALK) && (issue_q != DEPTH_C);
  assign walk_done   = (state_q == S_WALK) && !issuing && !pend_q;
  assign ts_in_range = (32'(ts_q) < TABLE_DEPTH);
  assign tidx        = IDX_W'(ts_q);
  assign ts_ok       = ts_in_range && valid_q[tidx];

  // Compare the entry that returns from memory this cycle
  assign pend_valid  = pend_q && valid_q[pend_idx_q];
  assign pend_match  = pend_valid &&
                       ((mode_q == MODE_CLIENT)
                          ? (rd_entry_q.sport == sport_q && rd_entry_q.addr == addr_q)
                          : (rd_entry_q.mport == mport_q));
  assign pend_better = pend_match && (!best_found_q || rd_rank_q < best_rank_q);
  assign pend_free   = pend_q && !valid_q[pend_idx_q] && !free_found_q;

  // New entry built from the item
  assign entry_wd = '{addr: addr_q, sport: sport_q, mport: mport_q, data: df_q};

  // Next state and memory control
  always_comb begin
    state_d  = state_q;
    load_out = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = issue_q[IDX_W-1:0];
    rank_we  = 1'b0;
    rank_wa  = pend_idx_q;
    rank_wd  = rd_rank_q;
    entry_we = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_START;
      end
      S_START: begin
        unique case (mode_q)
          MODE_INSERT: state_d = full ? S_FINISH : S_WALK;
          MODE_CLIENT, MODE_MAPPED: state_d = S_WALK;
          MODE_DELETE: begin
            if (ts_ok) begin
              rd_en   = 1'b1;
              rd_addr = tidx;
              state_d = S_DEL_CAP;
            end else begin
              state_d = S_FINISH;
            end
          end
          default: state_d = S_FINISH;
        endcase
      end
      S_DEL_CAP: state_d = S_WALK;
      S_WALK: begin
        rd_en = issuing;
        // age on insert, close the gap on delete
        if (pend_valid && mode_q == MODE_INSERT) begin
          rank_we = 1'b1;
          rank_wd = rd_rank_q + IDX_W'(1);
        end else if (pend_valid && mode_q == MODE_DELETE && rd_rank_q > del_rank_q) begin
          rank_we = 1'b1;
          rank_wd = rd_rank_q - IDX_W'(1);
        end
        if (walk_done) begin
          if (mode_q == MODE_INSERT) begin
            entry_we = 1'b1;
            rank_we  = 1'b1;
            rank_wa  = free_idx_q;
            rank_wd  = '0;
          end
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Form the result from the operation and what the walk found
  always_comb begin
    res_hit    = 1'b0;
    res_slot   = '0;
    res_sport  = '0;
    res_mport  = '0;
    res_addr   = '0;
    res_fin    = '0;
    res_data   = 1'b0;
    res_active = 1'b0;
    res_status = STATUS_MISS;
    unique case (mode_q)
      MODE_INSERT: begin
        if (fail_q) begin
          res_status = STATUS_FULL;
        end else begin
          res_hit    = 1'b1;
          res_slot   = SLOT_W'(free_idx_q);
          res_sport  = sport_q;
          res_mport  = mport_q;
          res_addr   = addr_q;
          res_fin    = FIN_START;
          res_data   = df_q;
          res_active = !df_q;
          res_status = STATUS_OK;
        end
      end
      MODE_CLIENT, MODE_MAPPED, MODE_DELETE: begin
        if (mode_q == MODE_DELETE) res_slot = ts_q;
        if ((mode_q == MODE_DELETE) ? !fail_q : best_found_q) begin
          res_hit    = 1'b1;
          if (mode_q != MODE_DELETE) res_slot = SLOT_W'(best_idx_q);
          res_sport  = best_entry_q.sport;
          res_mport  = best_entry_q.mport;
          res_addr   = best_entry_q.addr;
          res_fin    = FIN_START;
          res_data   = best_entry_q.data;
          res_active = !best_entry_q.data;
          res_status = STATUS_OK;
        end
      end
      MODE_CLEAR: begin
        res_hit    = 1'b1;
        res_status = STATUS_OK;
      end
      default: ;
    endcase
  end

  // Hold the sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Advance occupancy, walk pointers and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      count_q      <= '0;
      issue_q      <= '0;
      pend_q       <= 1'b0;
      best_found_q <= 1'b0;
      free_found_q <= 1'b0;
      fail_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      pend_q <= issuing;
      if (issuing) issue_q <= issue_q + CNT_W'(1);
      if (state_q == S_START) begin
        issue_q      <= '0;
        best_found_q <= 1'b0;
        free_found_q <= 1'b0;
        fail_q       <= (mode_q == MODE_INSERT && full) || (mode_q == MODE_DELETE && !ts_ok);
        if (mode_q == MODE_CLEAR) begin
          valid_q <= '0;
          count_q <= '0;
        end
      end
      if (state_q == S_DEL_CAP) begin
        valid_q[tidx] <= 1'b0;
        count_q       <= count_q - CNT_W'(1);
      end
      if (pend_better && mode_q != MODE_INSERT && mode_q != MODE_DELETE) best_found_q <= 1'b1;
      if (pend_free && mode_q == MODE_INSERT) free_found_q <= 1'b1;
      if (entry_we) begin
        valid_q[free_idx_q] <= 1'b1;
        count_q             <= count_q + CNT_W'(1);
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture item, walk results and output payload
  always_ff @(posedge clk_i) begin
    pend_idx_q <= issue_q[IDX_W-1:0];
    if (accept) begin
      mode_q  <= mode_i;
      sport_q <= key_source_port_i;
      mport_q <= key_mapped_port_i;
      addr_q  <= key_address_i;
      df_q    <= data_flag_i;
      ts_q    <= target_slot_i;
    end
    if (state_q == S_DEL_CAP) begin
      best_entry_q <= rd_entry_q;
      del_rank_q   <= rd_rank_q;
    end
    if (pend_better && mode_q != MODE_INSERT && mode_q != MODE_DELETE) begin
      best_idx_q   <= pend_idx_q;
      best_rank_q  <= rd_rank_q;
      best_entry_q <= rd_entry_q;
    end
    if (pend_free) free_idx_q <= pend_idx_q;
    if (load_out) begin
      hit_q    <= res_hit;
      slot_q   <= res_slot;
      osport_q <= res_sport;
      omport_q <= res_mport;
      oaddr_q  <= res_addr;
      fin_q    <= res_fin;
      odata_q  <= res_data;
      active_q <= res_active;
      status_q <= res_status;
    end
  end

  // Entry memory: one read port, one write port
  always_ff @(posedge clk_i) begin
    if (rd_en) rd_entry_q <= entry_mem[rd_addr];
    if (entry_we) entry_mem[free_idx_q] <= entry_wd;
  end

  // Rank memory: one read port, one write port
  always_ff @(posedge clk_i) begin
    if (rd_en) rd_rank_q <= rank_mem[rd_addr];
    if (rank_we) rank_mem[rank_wa] <= rank_wd;
  end

  assign out_valid_o       = out_valid_q;
  assign hit_o             = hit_q;
  assign slot_o            = slot_q;
  assign out_source_port_o = osport_q;
  assign out_mapped_port_o = omport_q;
  assign out_address_o     = oaddr_q;
  assign fin_left_o        = fin_q;
  assign out_data_flag_o   = odata_q;
  assign active_flag_o     = active_q;
  assign status_o          = status_q;

endmodule

// ===== src/cmt_checker.sv =====
// Port-level checks for connection_map_table, bound to every instance.
// Depends on cmt_pkg.
module cmt_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic                        hit_o,
  input logic [cmt_pkg::SLOT_W-1:0]  slot_o,
  input logic [cmt_pkg::FIN_W-1:0]   fin_left_o,
  input logic                        out_data_flag_o,
  input logic                        active_flag_o,
  input logic [cmt_pkg::STAT_W-1:0]  status_o
);
  import cmt_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(slot_o) && $stable(status_o))
    else $error("stalled result changed");

  // Hit goes with status ok and nothing else
  a_hit_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (hit_o == (status_o == STATUS_OK)))
    else $error("hit and status disagree");

  // Active flag is the inverse of the data flag, or both clear
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(active_flag_o && out_data_flag_o))
    else $error("active and data flags both set");

  // A miss or a full table carries no FIN count
  a_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> fin_left_o == '0 && !active_flag_o)
    else $error("failed result carries entry data");

  // Go busy once an item is taken
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item taken while busy");

endmodule

bind connection_map_table cmt_checker u_cmt_checker (.*);
